[hw/rtl/ptfl_pkg.sv]
// Shared constants and types for the paged translation unit.
// Has no dependencies; every other RTL file imports it.
`default_nettype none
package ptfl_pkg;
  localparam int ResidentPages = 3;
  localparam int MaxPages      = 16;
  localparam int Frames        = 64;

  localparam logic [1:0] OP_MAP_INIT = 2'd0;
  localparam logic [1:0] OP_CREATE   = 2'd1;
  localparam logic [1:0] OP_ACCESS   = 2'd2;
  localparam logic [1:0] OP_KILL     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NO_FRAME  = 2'd3;

  localparam logic [1:0] REG_PAGE_KB     = 2'd0;
  localparam logic [1:0] REG_CAPACITY_KB = 2'd1;
  localparam logic [1:0] REG_POLICY      = 2'd2;
  localparam logic [1:0] REG_INITIAL_MAP = 2'd3;

  localparam int DivW = 12;
  localparam int DsrW = 7;

  typedef logic [3:0] page_t;
  typedef logic [5:0] frame_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

[hw/rtl/ptfl_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ptfl_pkg for widths and the control struct.
`default_nettype none
module ptfl_div
  import ptfl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DivW-1:0]     dividend,
  input  logic [DsrW-1:0]     divisor,
  output div_ctl_t            ctl,
  output logic [DivW-1:0]     quotient,
  output logic [DsrW-1:0]     remainder
);
  logic [DivW-1:0] quo_r, quo_nxt;
  logic [DsrW-1:0] rem_r, rem_nxt;
  logic [DsrW-1:0] dsr_r;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [DsrW:0]   trial;
  logic [DsrW:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DivW-1]};
    diff     = trial - {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 4'(DivW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DsrW]) begin
        rem_nxt = diff[DsrW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DsrW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
      end
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

[hw/rtl/paged_translation_fifo_lru_top.sv]
// Top level of the demand-paging unit with FIFO or LRU replacement.
// Depends on ptfl_pkg and instantiates the divider ptfl_div.
`default_nettype none
// One item is taken at a time, and the input stalls until its result is in
// the output register. Map-init goes straight to the output step. Create and
// every access first pass through the divider; an access then reads the page
// table, and a hit or a fault with a victim goes on to the frame multiply. Kill
// walks the page table one entry per cycle. A fault with room in the resident
// list scans the frame map one frame per cycle up to the first free frame. The
// shared divider that splits addresses and sizes by the page size works through
// its 12-bit dividend one quotient bit at a time. A finished result waits in the
// output register while the next item is already accepted. A stall on the result
// channel holds the unit in its output step while the output register is full.
module paged_translation_fifo_lru_top
  import ptfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [19:0] in_logical_address,
  input  logic [20:0] in_process_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_page_fault,
  output logic [21:0] out_physical_address,
  output logic [15:0] out_page_offset,
  output logic [5:0]  out_frame_number,
  output logic        out_evicted_valid,
  output logic [3:0]  out_evicted_page,
  output logic [31:0] out_fault_count,
  output logic [31:0] out_access_count,
  output logic [4:0]  out_page_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_KILL = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [6:0]  page_kb_r;
  logic [10:0] capacity_kb_r;
  logic        policy_r;
  logic [63:0] initial_map_r;

  logic [2:0]  state_r;
  logic [1:0]  op_r;
  logic [19:0] addr_r;
  logic [20:0] size_r;
  logic [63:0] frame_map_r;
  frame_t      page_frame_r [MaxPages];
  logic [MaxPages-1:0] present_r;
  page_t       order_r [ResidentPages];
  page_t       order_nxt [ResidentPages];
  logic [1:0]  fill_r;
  logic [4:0]  pic_r;
  logic [31:0] faults_r;
  logic [31:0] accesses_r;
  logic [5:0]  fcnt_r;
  logic [3:0]  kcnt_r;
  page_t       p_r;
  frame_t      frame_r;
  logic [11:0] mul_r;

  logic [1:0]  res_status_r;
  logic        res_fault_r;
  logic        res_ok_r;
  logic        res_ev_valid_r;
  page_t       res_ev_page_r;
  logic [15:0] res_offs_r;

  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic        o_fault_r;
  logic [21:0] o_phys_r;
  logic [15:0] o_offs_r;
  frame_t      o_frame_r;
  logic        o_ev_valid_r;
  page_t       o_ev_page_r;
  logic [31:0] o_faults_r;
  logic [31:0] o_accesses_r;
  logic [4:0]  o_pages_r;

  logic [6:0]  k_eff;
  logic        div_start;
  logic [11:0] div_dividend;
  div_ctl_t    div_ctl;
  logic [11:0] div_q;
  logic [6:0]  div_r;
  logic [3:0]  rd_idx;
  frame_t      rd_frame;
  page_t       pg;
  logic        pg_ok;
  logic [12:0] pages;
  logic        accept;
  logic        touch_hit;
  logic [1:0]  touch_pos;

  assign k_eff = (page_kb_r == 7'd0) ? 7'd1 : ((page_kb_r > 7'd64) ? 7'd64 : page_kb_r);
  assign accept = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign div_start = (state_r == S_DIV) && !div_ctl.busy && !res_ok_r;
  assign div_dividend = (op_r == OP_CREATE) ?
      ({1'b0, size_r[20:10]} + {11'd0, |size_r[9:0]}) : {2'b00, addr_r[19:10]};

  ptfl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (k_eff),
    .ctl       (div_ctl),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign pg    = div_q[3:0];
  assign pg_ok = (div_q < {7'd0, pic_r}) && (div_q < 12'(MaxPages));
  assign pages = {1'b0, div_q} + {12'd0, (div_r != 7'd0)};

  always_comb begin
    rd_idx = p_r;
    if (state_r == S_KILL) begin
      rd_idx = kcnt_r;
    end else if (state_r == S_EVAL) begin
      rd_idx = (present_r[pg] || fill_r < 2'(ResidentPages)) ? pg : order_r[0];
    end
  end
  assign rd_frame = page_frame_r[rd_idx];

  always_comb begin
    touch_hit = 1'b0;
    touch_pos = '0;
    for (int i = ResidentPages - 1; i >= 0; i--) begin
      if ((2'(i) < fill_r) && (order_r[i] == pg)) begin
        touch_hit = 1'b1;
        touch_pos = 2'(i);
      end
    end
    for (int j = 0; j < ResidentPages; j++) begin
      order_nxt[j] = order_r[j];
    end
    if (touch_hit) begin
      for (int j = 0; j < ResidentPages - 1; j++) begin
        if ((2'(j) >= touch_pos) && (2'(j + 1) < fill_r)) begin
          order_nxt[j] = order_r[j + 1];
        end
      end
      order_nxt[fill_r - 2'd1] = pg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_kb_r     <= 7'd1;
      capacity_kb_r <= 11'd8;
      policy_r      <= 1'b0;
      initial_map_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAGE_KB:     page_kb_r     <= cfg_data[6:0];
        REG_CAPACITY_KB: capacity_kb_r <= cfg_data[10:0];
        REG_POLICY:      policy_r      <= cfg_data[0];
        REG_INITIAL_MAP: initial_map_r <= cfg_data;
        default:         policy_r      <= policy_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_map_r <= '0;
      present_r   <= '0;
      fill_r      <= '0;
      pic_r       <= '0;
      faults_r    <= '0;
      accesses_r  <= '0;
      out_valid_r <= 1'b0;
      res_ok_r    <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r           <= in_opcode;
            addr_r         <= in_logical_address;
            size_r         <= in_process_bytes;
            res_status_r   <= ST_OK;
            res_fault_r    <= 1'b0;
            res_ok_r       <= 1'b0;
            res_ev_valid_r <= 1'b0;
            res_ev_page_r  <= '0;
            res_offs_r     <= '0;
            kcnt_r         <= '0;
            fcnt_r         <= '0;
            unique case (in_opcode)
              OP_MAP_INIT: begin
                frame_map_r <= initial_map_r;
                state_r     <= S_OUT;
              end
              OP_KILL: state_r <= S_KILL;
              default: state_r <= S_DIV;
            endcase
          end
        end
        S_DIV: begin
          if (res_ok_r && !div_ctl.busy) begin
            res_ok_r <= 1'b0;
            state_r  <= S_EVAL;
          end else begin
            res_ok_r <= 1'b1;
          end
        end
        S_EVAL: begin
          state_r <= S_OUT;
          if (op_r == OP_CREATE) begin
            if ({size_r} > {capacity_kb_r, 10'd0} || pages > 13'(MaxPages)) begin
              res_status_r <= ST_TOO_LARGE;
            end else begin
              pic_r      <= pages[4:0];
              present_r  <= '0;
              fill_r     <= '0;
              faults_r   <= '0;
              accesses_r <= '0;
            end
          end else begin
            res_offs_r <= {div_r[5:0], addr_r[9:0]};
            p_r        <= pg;
            if (!pg_ok) begin
              res_status_r <= ST_RANGE;
            end else if (present_r[pg]) begin
              if (policy_r) begin
                for (int j = 0; j < ResidentPages; j++) begin
                  order_r[j] <= order_nxt[j];
                end
              end
              frame_r <= rd_frame;
              state_r <= S_MUL;
            end else if (fill_r < 2'(ResidentPages)) begin
              state_r <= S_SCAN;
            end else begin
              page_frame_r[pg] <= rd_frame;
              present_r <= (present_r & ~(MaxPages'(1) << order_r[0]))
                           | (MaxPages'(1) << pg);
              for (int j = 0; j < ResidentPages - 1; j++) begin
                order_r[j] <= order_r[j + 1];
              end
              order_r[ResidentPages - 1] <= pg;
              res_fault_r    <= 1'b1;
              res_ev_valid_r <= 1'b1;
              res_ev_page_r  <= order_r[0];
              frame_r        <= rd_frame;
              state_r        <= S_MUL;
            end
          end
        end
        S_SCAN: begin
          fcnt_r <= fcnt_r + 6'd1;
          if (!frame_map_r[fcnt_r]) begin
            frame_map_r[fcnt_r] <= 1'b1;
            page_frame_r[p_r]   <= fcnt_r;
            present_r[p_r]      <= 1'b1;
            order_r[fill_r]     <= p_r;
            fill_r              <= fill_r + 2'd1;
            res_fault_r         <= 1'b1;
            frame_r             <= fcnt_r;
            state_r             <= S_MUL;
          end else if (fcnt_r == 6'(Frames - 1)) begin
            res_status_r <= ST_NO_FRAME;
            state_r      <= S_OUT;
          end
        end
        S_MUL: begin
          mul_r      <= 12'({6'd0, frame_r} * {5'd0, k_eff});
          res_ok_r   <= 1'b1;
          accesses_r <= accesses_r + 32'd1;
          if (res_fault_r) begin
            faults_r <= faults_r + 32'd1;
          end
          state_r <= S_OUT;
        end
        S_KILL: begin
          kcnt_r <= kcnt_r + 4'd1;
          if (present_r[kcnt_r]) begin
            frame_map_r[rd_frame] <= 1'b0;
          end
          if (kcnt_r == 4'(MaxPages - 1)) begin
            present_r <= '0;
            fill_r    <= '0;
            pic_r     <= '0;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            o_status_r   <= res_status_r;
            o_fault_r    <= res_fault_r && res_ok_r;
            o_phys_r     <= res_ok_r ? ({mul_r, 10'd0} + {6'd0, res_offs_r}) : '0;
            o_offs_r     <= res_offs_r;
            o_frame_r    <= res_ok_r ? frame_r : '0;
            o_ev_valid_r <= res_ev_valid_r;
            o_ev_page_r  <= res_ev_page_r;
            o_faults_r   <= faults_r;
            o_accesses_r <= accesses_r;
            o_pages_r    <= pic_r;
            res_ok_r     <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_page_fault       = o_fault_r;
  assign out_physical_address = o_phys_r;
  assign out_page_offset      = o_offs_r;
  assign out_frame_number     = o_frame_r;
  assign out_evicted_valid    = o_ev_valid_r;
  assign out_evicted_page     = o_ev_page_r;
  assign out_fault_count      = o_faults_r;
  assign out_access_count     = o_accesses_r;
  assign out_page_count       = o_pages_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 2'(ResidentPages))
    else $error("Resident list holds more pages than allowed.");
  a_err_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_page_fault && !out_evicted_valid)
    else $error("An item with an error reports a fault or an eviction.");
  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pic_r <= 5'(MaxPages))
    else $error("Page count exceeds the page table.");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT)
    else $error("A result appeared outside the output step.");
endmodule
`default_nettype wire
